// ===== rtl/core/hmus_pkg.sv =====
// Package for the health-masked upstream selector: sizes, operation and rule
// codes, register map, shared structs and small mask helper functions.
// Used by every RTL file of the block; depends on nothing.
`default_nettype none

package hmus_pkg;

  localparam int POOL_SIZE = 16;
  localparam int IDX_W     = $clog2(POOL_SIZE);
  localparam int CNT_W     = $clog2(POOL_SIZE + 1);
  localparam int RULE_W    = 3;
  localparam int TICK_W    = 16;
  localparam int LFSR_W    = 16;
  localparam int DATA_W    = 32;
  localparam int PADDR_W   = 4;

  localparam logic [LFSR_W-1:0] LFSR_SEED        = 16'hACE1;
  localparam logic [TICK_W-1:0] INTERVAL_DEFAULT = 16'd1000;

  typedef enum logic [2:0] {
    OP_SELECT       = 3'd0,
    OP_TCP_OK       = 3'd1,
    OP_TCP_FAIL     = 3'd2,
    OP_CONNECT_OK   = 3'd3,
    OP_CONNECT_FAIL = 3'd4,
    OP_MANUAL_OFF   = 3'd5,
    OP_FORCE_LAST   = 3'd6,
    OP_TICK         = 3'd7
  } op_t;

  typedef enum logic [RULE_W-1:0] {
    RULE_INHERIT     = 3'd0,
    RULE_FIXED       = 3'd1,
    RULE_ROUND_ROBIN = 3'd2,
    RULE_STICKY      = 3'd3,
    RULE_TIMED       = 3'd4,
    RULE_RANDOM      = 3'd5
  } rule_t;

  typedef enum logic [1:0] {
    REG_GLOBAL_RULE     = 2'd0,
    REG_PROBE_CHECK_OFF = 2'd1,
    REG_POOL_COUNT      = 2'd2,
    REG_CHANGE_INTERVAL = 2'd3
  } reg_addr_t;

  typedef struct packed {
    logic [RULE_W-1:0] global_rule;
    logic              probe_check_off;
    logic [CNT_W-1:0]  pool_count;
    logic [TICK_W-1:0] change_interval;
  } cfg_t;

  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  server_index;
    logic [RULE_W-1:0] rule;
    logic              use_global_fallback;
    logic              flag_value;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] index;
    logic             upd_last;
    logic [IDX_W-1:0] new_last;
    logic             clr_elapsed;
    logic             step_lfsr;
  } pick_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } hit_t;

  // Priority encoder: lowest set bit of a pool-wide mask.
  function automatic hit_t lowest_set(input logic [POOL_SIZE-1:0] m);
    hit_t r;
    r = '0;
    for (int i = POOL_SIZE - 1; i >= 0; i--) begin
      if (m[i]) begin
        r.hit = 1'b1;
        r.idx = IDX_W'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] count_ones(input logic [POOL_SIZE-1:0] m);
    logic [CNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      c = c + CNT_W'(m[i]);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hmus_if.sv =====
// Request and response channel interfaces of the upstream selector.
// Depends on hmus_pkg for field widths.
`default_nettype none

interface hmus_req_if import hmus_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        op;
  logic [IDX_W-1:0]  server_index;
  logic [RULE_W-1:0] rule;
  logic              use_global_fallback;
  logic              flag_value;

  modport source (output valid, op, server_index, rule, use_global_fallback, flag_value,
                  input ready);
  modport sink   (input valid, op, server_index, rule, use_global_fallback, flag_value,
                  output ready);
  modport mon    (input valid, ready, op, server_index, rule, use_global_fallback,
                  flag_value);
endinterface

interface hmus_rsp_if import hmus_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [IDX_W-1:0] chosen_index;

  modport source (output valid, found, chosen_index, input ready);
  modport sink   (input valid, found, chosen_index, output ready);
  modport mon    (input valid, ready, found, chosen_index);
endinterface

`default_nettype wire

// ===== rtl/core/hmus_cfg.sv =====
// APB-style configuration register file of the upstream selector.
// Depends on hmus_pkg for the register map and the cfg_t struct.
`default_nettype none

module hmus_cfg import hmus_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  output cfg_t               cfg
);

  reg_addr_t reg_addr;
  logic      wr_en;

  assign pready   = 1'b1;
  assign reg_addr = reg_addr_t'(paddr[PADDR_W-1:2]);
  assign wr_en    = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.global_rule     <= RULE_ROUND_ROBIN;
      cfg.probe_check_off <= 1'b0;
      cfg.pool_count      <= '0;
      cfg.change_interval <= INTERVAL_DEFAULT;
    end else if (wr_en) begin
      unique case (reg_addr)
        REG_GLOBAL_RULE:     cfg.global_rule     <= pwdata[RULE_W-1:0];
        REG_PROBE_CHECK_OFF: cfg.probe_check_off <= pwdata[0];
        REG_POOL_COUNT:      cfg.pool_count      <= pwdata[CNT_W-1:0];
        REG_CHANGE_INTERVAL: cfg.change_interval <= pwdata[TICK_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_addr)
      REG_GLOBAL_RULE:     prdata = DATA_W'(cfg.global_rule);
      REG_PROBE_CHECK_OFF: prdata = DATA_W'(cfg.probe_check_off);
      REG_POOL_COUNT:      prdata = DATA_W'(cfg.pool_count);
      REG_CHANGE_INTERVAL: prdata = DATA_W'(cfg.change_interval);
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/hmus_flags.sv =====
// Per-server health flag registers and the eligibility mask built from them.
// Depends on hmus_pkg for sizes, op codes and the req_t struct.
`default_nettype none

module hmus_flags import hmus_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 ev_en,
  input  req_t                 item,
  input  logic                 probe_check_off,
  input  logic [CNT_W-1:0]     pool_n,
  output logic [POOL_SIZE-1:0] elig
);

  logic [POOL_SIZE-1:0] has_online, has_online_next;
  logic [POOL_SIZE-1:0] has_connect, has_connect_next;
  logic [POOL_SIZE-1:0] connect_failed, connect_failed_next;
  logic [POOL_SIZE-1:0] offline, offline_next;
  logic [POOL_SIZE-1:0] manual_off, manual_off_next;
  logic [POOL_SIZE-1:0] sel_bit;
  logic [POOL_SIZE-1:0] pool_mask;
  logic [POOL_SIZE-1:0] ok;

  assign sel_bit = POOL_SIZE'(1) << item.server_index;

  always_comb begin
    has_online_next     = has_online;
    has_connect_next    = has_connect;
    connect_failed_next = connect_failed;
    offline_next        = offline;
    manual_off_next     = manual_off;
    if (ev_en) begin
      unique case (item.op)
        OP_TCP_OK: begin
          // A server coming back from offline also forgets its connect failure.
          if ((offline & sel_bit) != '0) begin
            connect_failed_next = connect_failed & ~sel_bit;
          end
          has_online_next = has_online | sel_bit;
          offline_next    = offline & ~sel_bit;
        end
        OP_TCP_FAIL: offline_next = offline | sel_bit;
        OP_CONNECT_OK: begin
          has_connect_next    = has_connect | sel_bit;
          connect_failed_next = connect_failed & ~sel_bit;
        end
        OP_CONNECT_FAIL: connect_failed_next = connect_failed | sel_bit;
        OP_MANUAL_OFF: begin
          manual_off_next = item.flag_value ? (manual_off | sel_bit)
                                            : (manual_off & ~sel_bit);
        end
        OP_SELECT, OP_FORCE_LAST, OP_TICK: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      has_online     <= '0;
      has_connect    <= '0;
      connect_failed <= '0;
      offline        <= '0;
      manual_off     <= '0;
    end else begin
      has_online     <= has_online_next;
      has_connect    <= has_connect_next;
      connect_failed <= connect_failed_next;
      offline        <= offline_next;
      manual_off     <= manual_off_next;
    end
  end

  always_comb begin
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_mask[i] = CNT_W'(i) < pool_n;
    end
    ok = ~manual_off;
    if (!probe_check_off) begin
      ok = ok & has_online & has_connect & ~connect_failed & ~offline;
    end
    elig = ok & pool_mask;
  end

endmodule

`default_nettype wire

// ===== rtl/core/hmus_pick.sv =====
// Selection logic: resolves the rule and picks the last index (fixed rule) or an
// eligible server by masked priority encoding or as the k-th eligible server.
// Depends on hmus_pkg for sizes, rule codes, structs and mask helpers.
`default_nettype none

module hmus_pick import hmus_pkg::*; (
  input  req_t                 item,
  input  cfg_t                 cfg,
  input  logic [CNT_W-1:0]     pool_n,
  input  logic [POOL_SIZE-1:0] elig,
  input  logic [IDX_W-1:0]     last_index,
  input  logic [TICK_W-1:0]    elapsed_ticks,
  input  logic [LFSR_W-1:0]    lfsr,
  output pick_t                pick
);

  logic [RULE_W-1:0]       eff_rule;
  logic                    no_go;
  logic                    last_ok;
  logic                    timed_move;
  logic                    use_rr;
  logic [CNT_W-1:0]        last_p1;
  logic [IDX_W-1:0]        rr_start;
  logic [IDX_W-1:0]        sticky_start;
  logic [IDX_W-1:0]        scan_start;
  logic [POOL_SIZE-1:0]    from_mask;
  logic [POOL_SIZE-1:0]    match;
  logic [POOL_SIZE-1:0]    low_mask;
  hit_t                    hit_hi;
  hit_t                    hit_all;
  hit_t                    hit_scan;
  hit_t                    hit_rand;
  logic [CNT_W-1:0]        elig_cnt;
  logic [CNT_W-1:0]        k;
  logic [CNT_W-1:0]        prefix [POOL_SIZE];
  logic [LFSR_W+CNT_W-1:0] prod;

  always_comb begin
    eff_rule = (item.rule == RULE_INHERIT) ? cfg.global_rule : item.rule;
    no_go    = ((item.rule == RULE_INHERIT) && !item.use_global_fallback) ||
               (pool_n == '0);

    last_ok      = CNT_W'(last_index) < pool_n;
    last_p1      = CNT_W'(last_index) + CNT_W'(1);
    rr_start     = (last_p1 >= pool_n) ? '0 : last_p1[IDX_W-1:0];
    sticky_start = last_ok ? last_index : '0;
    timed_move   = elapsed_ticks > cfg.change_interval;
    use_rr       = (eff_rule == RULE_ROUND_ROBIN) || ((eff_rule == RULE_TIMED) && timed_move);
    scan_start   = use_rr ? rr_start : sticky_start;

    // Wrapping scan: first eligible at or above the start, else the first overall.
    for (int i = 0; i < POOL_SIZE; i++) begin
      from_mask[i] = IDX_W'(i) >= scan_start;
    end
    hit_hi   = lowest_set(elig & from_mask);
    hit_all  = lowest_set(elig);
    hit_scan = hit_hi.hit ? hit_hi : hit_all;

    // Random rule: k = (lfsr * count) >> 16, then the k-th eligible server.
    elig_cnt = count_ones(elig);
    prod     = (LFSR_W+CNT_W)'(lfsr) * (LFSR_W+CNT_W)'(elig_cnt);
    k        = prod[LFSR_W+CNT_W-1:LFSR_W];
    for (int i = 0; i < POOL_SIZE; i++) begin
      low_mask  = (POOL_SIZE'(1) << i) - POOL_SIZE'(1);
      prefix[i] = count_ones(elig & low_mask);
      match[i]  = elig[i] && (prefix[i] == k);
    end
    hit_rand = lowest_set(match);

    pick = '0;
    if (!no_go) begin
      unique case (eff_rule)
        RULE_FIXED: begin
          pick.found = 1'b1;
          pick.index = sticky_start;
        end
        RULE_ROUND_ROBIN, RULE_STICKY, RULE_TIMED: begin
          pick.found       = hit_scan.hit;
          pick.index       = hit_scan.hit ? hit_scan.idx : '0;
          pick.upd_last    = 1'b1;
          pick.new_last    = hit_scan.hit ? hit_scan.idx : sticky_start;
          pick.clr_elapsed = (eff_rule == RULE_TIMED) && timed_move;
        end
        default: begin
          pick.found     = elig_cnt != '0;
          pick.index     = pick.found ? hit_rand.idx : '0;
          pick.upd_last  = pick.found;
          pick.new_last  = hit_rand.idx;
          pick.step_lfsr = pick.found;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/health_masked_upstream_selector.sv =====
// Top level of the health-masked upstream selector: request register, state
// update, result register. Depends on hmus_pkg, hmus_if, hmus_cfg,
// hmus_flags and hmus_pick.
//
// Usage:
//   The req channel carries one request per handshake (valid and ready both
//   high at a rising edge): a select, a probe result event, a manual disable,
//   a forced last index or a tick. Every request produces exactly one
//   response on the rsp channel; only a select can answer found = 1.
//   Registers are written through the APB-style port (byte address 4*i),
//   while no request is in flight.
//   A request accepted into the request register is evaluated there, and its
//   response is captured in the result register, from which it is taken.
//   Throughput: one request per cycle while the receiver takes every response.
//   The loop that reads the health flags, last index, tick counter and LFSR
//   writes them back while the response is registered.
//   When the receiver stalls, the response register holds its value, the
//   request register fills, and req.ready drops while it is full; nothing is
//   lost or repeated.
//   Reset (synchronous, active high) clears all health flags, the last index
//   and the tick counter at once, loads the LFSR seed and the register
//   defaults; requests are accepted in the cycle after reset.
`default_nettype none

module health_masked_upstream_selector import hmus_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  hmus_req_if.sink           req,
  hmus_rsp_if.source         rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  cfg_t                 cfg;
  req_t                 s1_item;
  logic                 s1_valid;
  logic                 out_valid;
  logic                 out_found;
  logic [IDX_W-1:0]     out_index;
  logic                 advance;
  logic                 process;
  logic                 in_pool;
  logic                 sel_found;
  logic [CNT_W-1:0]     pool_n;
  logic [POOL_SIZE-1:0] elig;
  pick_t                pick;
  logic [IDX_W-1:0]     last_index, last_index_next;
  logic [TICK_W-1:0]    elapsed_ticks, elapsed_ticks_next;
  logic [LFSR_W-1:0]    lfsr, lfsr_next;
  logic                 lfsr_fb;

  hmus_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Effective pool size is the configured count clipped to the pool capacity.
  assign pool_n  = (cfg.pool_count > CNT_W'(POOL_SIZE)) ? CNT_W'(POOL_SIZE) : cfg.pool_count;
  assign in_pool = CNT_W'(s1_item.server_index) < pool_n;

  // The request in the input register is evaluated whenever the result
  // register is free or being emptied in this cycle.
  assign advance   = !out_valid || rsp.ready;
  assign process   = s1_valid && advance;
  assign req.ready = !s1_valid || advance;

  hmus_flags u_flags (
    .clk             (clk),
    .rst             (rst),
    .ev_en           (process && in_pool),
    .item            (s1_item),
    .probe_check_off (cfg.probe_check_off),
    .pool_n          (pool_n),
    .elig            (elig)
  );

  hmus_pick u_pick (
    .item          (s1_item),
    .cfg           (cfg),
    .pool_n        (pool_n),
    .elig          (elig),
    .last_index    (last_index),
    .elapsed_ticks (elapsed_ticks),
    .lfsr          (lfsr),
    .pick          (pick)
  );

  assign lfsr_fb   = lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5];
  assign sel_found = (s1_item.op == OP_SELECT) && pick.found;

  always_comb begin
    last_index_next    = last_index;
    elapsed_ticks_next = elapsed_ticks;
    lfsr_next          = lfsr;
    if (process) begin
      unique case (s1_item.op)
        OP_SELECT: begin
          if (pick.upd_last) begin
            last_index_next = pick.new_last;
          end
          if (pick.clr_elapsed) begin
            elapsed_ticks_next = '0;
          end
          if (pick.step_lfsr) begin
            lfsr_next = {lfsr_fb, lfsr[LFSR_W-1:1]};
          end
        end
        OP_FORCE_LAST: begin
          if (in_pool) begin
            last_index_next = s1_item.server_index;
          end
        end
        OP_TICK: begin
          // The tick counter saturates instead of wrapping.
          if (elapsed_ticks != '1) begin
            elapsed_ticks_next = elapsed_ticks + TICK_W'(1);
          end
        end
        OP_TCP_OK, OP_TCP_FAIL, OP_CONNECT_OK, OP_CONNECT_FAIL, OP_MANUAL_OFF: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      last_index    <= '0;
      elapsed_ticks <= '0;
      lfsr          <= LFSR_SEED;
    end else begin
      if (req.ready) begin
        s1_valid <= req.valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
      last_index    <= last_index_next;
      elapsed_ticks <= elapsed_ticks_next;
      lfsr          <= lfsr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_item.op                  <= op_t'(req.op);
      s1_item.server_index        <= req.server_index;
      s1_item.rule                <= req.rule;
      s1_item.use_global_fallback <= req.use_global_fallback;
      s1_item.flag_value          <= req.flag_value;
    end
    if (process) begin
      out_found <= sel_found;
      out_index <= sel_found ? pick.index : '0;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.found        = out_found;
  assign rsp.chosen_index = out_index;

endmodule

`default_nettype wire

// ===== rtl/core/hmus_checker.sv =====
// Port-level checker for the upstream selector and its bind to the top level.
// Depends on hmus_pkg and hmus_if.
`default_nettype none

module hmus_checker import hmus_pkg::*; (
  input logic               clk,
  input logic               rst,
  hmus_req_if.sink          req,
  hmus_rsp_if.source        rsp,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [PADDR_W-1:0] paddr,
  input logic [DATA_W-1:0]  pwdata,
  input logic [DATA_W-1:0]  prdata,
  input logic               pready
);

  // A stalled response keeps its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.found) && $stable(rsp.chosen_index))
    else $error("response changed while stalled");

  // A response without a server always reports index zero.
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.found |-> rsp.chosen_index == '0)
    else $error("index not zero on a response without a server");

  // Reset empties both pipeline registers.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp.valid && req.ready)
    else $error("pipeline not empty after reset");

  // A pool count write reads back on the next cycle.
  a_pool_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_POOL_COUNT) ##1
    (psel && !pwrite && paddr[PADDR_W-1:2] == REG_POOL_COUNT)
    |-> prdata == DATA_W'($past(pwdata[CNT_W-1:0])))
    else $error("pool count readback mismatch");

endmodule

bind health_masked_upstream_selector hmus_checker u_hmus_checker (
  .clk     (clk),
  .rst     (rst),
  .req     (req),
  .rsp     (rsp),
  .psel    (psel),
  .penable (penable),
  .pwrite  (pwrite),
  .paddr   (paddr),
  .pwdata  (pwdata),
  .prdata  (prdata),
  .pready  (pready)
);

`default_nettype wire
